// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the converter checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that stays active through reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_DIS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== hw/rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths, fixed constants and the hue sector codes.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W    = 9;
  localparam int PCT_W    = 7;
  localparam int CH_W     = 8;
  localparam int WGT_W    = 6;
  localparam int PROD_W   = 14;
  localparam int RW_W     = 12;
  localparam int HUE_SPAN = 60;
  localparam int PCT_SQ   = 10000;

  localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Sector of the hue circle, in steps of sixty degrees.
  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_t;

endpackage

// ===== hw/rtl/hsv2rgb_cdiv.sv =====
// ----------------------------------------------------------------------------
// Constant divider
// Three-stage floor(num * 2^PRE / D) by reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module hsv2rgb_cdiv #(
  parameter int NW  = 14,
  parameter int PRE = 0,
  parameter int D   = 60,
  parameter int QW  = 8
) (
  input  logic                  clk,
  input  logic [2:0]            en,
  input  logic [NW-1:0]         num,
  output logic [QW-1:0]         quo,
  output logic [$clog2(D)-1:0]  rem
);

  localparam int RW   = PRE + NW - $clog2(D) + 1;
  localparam int RMW  = $clog2(2 * D);
  localparam int REMW = $clog2(D);
  localparam int DW   = $clog2(D + 1);
  localparam longint unsigned RVAL = (64'd1 << (PRE + NW)) / D;
  localparam logic [RW-1:0]  RV = RW'(RVAL);
  localparam logic [DW-1:0]  DV = DW'(D);
  localparam logic [RMW-1:0] DR = RMW'(D);

  logic [NW+RW-1:0]  prod;
  logic [NW+RW-1:0]  prod_a;
  logic [NW+PRE-1:0] numf;
  logic [RMW-1:0]    low_a;
  logic [RMW-1:0]    low_b;
  logic [QW-1:0]     qest;
  logic [QW-1:0]     qest_b;
  logic [QW+DW-1:0]  qd;
  logic [RMW-1:0]    qd_b;
  logic [RMW-1:0]    diff;

  // The estimate is low by at most one, so the true remainder of the estimate
  // lies below 2*D and only its low bits need to be formed.
  assign prod = (NW+RW)'(num) * (NW+RW)'(RV);
  assign numf = (NW+PRE)'(num) << PRE;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_a <= prod;
      low_a  <= numf[RMW-1:0];
    end
  end

  assign qest = prod_a[NW +: QW];
  assign qd   = (QW+DW)'(qest) * (QW+DW)'(DV);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      qest_b <= qest;
      qd_b   <= qd[RMW-1:0];
      low_b  <= low_a;
    end
  end

  assign diff = low_b - qd_b;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (diff >= DR) begin
        quo <= qest_b + QW'(1);
        rem <= REMW'(diff - DR);
      end else begin
        quo <= qest_b;
        rem <= REMW'(diff);
      end
    end
  end

endmodule

// ===== hw/rtl/hsv_to_rgb_converter_top.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts hue in degrees and saturation and value in percent to 8-bit RGB.
// A new transaction can be taken on every clock and a result leaves on every
// clock while the output is not stalled. The pipeline is 13 register stages
// deep, the last of them the output register. The depth is set by three
// chained constant dividers (by 10000, by 60 on the chroma, and by 60 on
// the residue product), each three stages deep. Every stage holds its own
// valid bit, so empty stages fill while the output is stalled. Hue codes
// above 360 give black; saturation and value above 100 are taken as 100.
// Internal values are unsigned fixed point with FRAC_BITS fractional bits;
// each channel is scaled by 255 and rounded half up.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [HUE_W-1:0]  hue_degrees,
  input  logic [PCT_W-1:0]  saturation_pct,
  input  logic [PCT_W-1:0]  value_pct,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   red,
  output logic [CH_W-1:0]   green,
  output logic [CH_W-1:0]   blue
);

  localparam int FB  = FRAC_BITS;
  localparam int NST = 13;
  localparam int QAW = FB - 4;
  localparam logic [FB:0] HALF = (FB+1)'(1) << (FB - 1);

  typedef struct packed {
    logic             black;
    sector_t          sector;
    logic [WGT_W-1:0] w;
    logic [FB:0]      vf;
    logic [FB:0]      m;
    logic [FB:0]      aw;
  } side_t;

  logic [NST-1:0]    vld;
  logic [NST-1:0]    en;
  side_t             side      [NST-1];
  side_t             side_next [NST-1];
  side_t             side_in;

  logic [PCT_W-1:0]  s_cl;
  logic [PCT_W-1:0]  v_cl;
  logic [HUE_W-1:0]  hm;
  logic [WGT_W-1:0]  hue_dist;
  logic [PROD_W-1:0] pc0;
  logic [PROD_W-1:0] pv0;

  logic [FB:0]       c3;
  logic [FB:0]       vf3;
  logic [QAW-1:0]    a6;
  logic [WGT_W-1:0]  r6;
  logic [RW_W-1:0]   rw7;
  logic [WGT_W-1:0]  q10;
  logic [FB:0]       xm11;

  logic [CH_W-1:0]   hi;
  logic [CH_W-1:0]   mid;
  logic [CH_W-1:0]   lo;
  logic [CH_W-1:0]   red_next;
  logic [CH_W-1:0]   green_next;
  logic [CH_W-1:0]   blue_next;

  function automatic logic [CH_W-1:0] rnd(input logic [FB:0] q);
    logic [FB+CH_W:0] t;
    t = {q, {CH_W{1'b0}}} - (FB+CH_W+1)'(q) + (FB+CH_W+1)'(HALF);
    return t[FB+CH_W-1:FB];
  endfunction

  // Stage enables: a stage moves when it is empty or the next one moves.
  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Input decode: clamp, black flag, sector, and distance from the sector pair center.
  always_comb begin
    s_cl = (saturation_pct > PCT_MAX) ? PCT_MAX : saturation_pct;
    v_cl = (value_pct > PCT_MAX) ? PCT_MAX : value_pct;

    if (hue_degrees >= HUE_MAX) begin
      hm = hue_degrees - HUE_MAX;
    end else if (hue_degrees >= HUE_W'(4 * HUE_SPAN)) begin
      hm = hue_degrees - HUE_W'(4 * HUE_SPAN);
    end else if (hue_degrees >= HUE_W'(2 * HUE_SPAN)) begin
      hm = hue_degrees - HUE_W'(2 * HUE_SPAN);
    end else begin
      hm = hue_degrees;
    end

    if (hm >= HUE_W'(HUE_SPAN)) begin
      hue_dist = WGT_W'(hm - HUE_W'(HUE_SPAN));
    end else begin
      hue_dist = WGT_W'(HUE_W'(HUE_SPAN) - hm);
    end

    side_in        = '0;
    side_in.black  = hue_degrees > HUE_MAX;
    side_in.w      = WGT_W'(HUE_SPAN) - hue_dist;
    if (hue_degrees < HUE_W'(HUE_SPAN)) begin
      side_in.sector = SEC_R_Y;
    end else if (hue_degrees < HUE_W'(2 * HUE_SPAN)) begin
      side_in.sector = SEC_Y_G;
    end else if (hue_degrees < HUE_W'(3 * HUE_SPAN)) begin
      side_in.sector = SEC_G_C;
    end else if (hue_degrees < HUE_W'(4 * HUE_SPAN)) begin
      side_in.sector = SEC_C_B;
    end else if (hue_degrees < HUE_W'(5 * HUE_SPAN)) begin
      side_in.sector = SEC_B_M;
    end else begin
      side_in.sector = SEC_M_R;
    end
  end

  // Side data moves along with the stages; later stages fill fields as their
  // values become known.
  always_comb begin
    side_next[0] = side_in;
    for (int i = 1; i < NST - 1; i++) begin
      side_next[i] = side[i-1];
    end
    side_next[4].vf = vf3;
    side_next[4].m  = vf3 - c3;
    side_next[7].aw = (FB+1)'(a6) * (FB+1)'(side[6].w);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pc0     <= PROD_W'(s_cl) * PROD_W'(v_cl);
      pv0     <= PROD_W'(v_cl) * PROD_W'(PCT_MAX);
    end
    for (int i = 0; i < NST - 1; i++) begin
      if (en[i]) begin
        side[i] <= side_next[i];
      end
    end
    if (en[7]) begin
      rw7        <= RW_W'(r6) * RW_W'(side[6].w);
    end
    if (en[11]) begin
      xm11 <= side[10].aw + (FB+1)'(q10) + side[10].m;
    end
    if (en[12]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  // Chroma and value, both as a fraction of 10000 scaled to fixed point.
  hsv2rgb_cdiv #(
    .NW  (PROD_W),
    .PRE (FB),
    .D   (PCT_SQ),
    .QW  (FB + 1)
  ) u_div_c (
    .clk (clk),
    .en  (en[3:1]),
    .num (pc0),
    .quo (c3),
    .rem ()
  );

  hsv2rgb_cdiv #(
    .NW  (PROD_W),
    .PRE (FB),
    .D   (PCT_SQ),
    .QW  (FB + 1)
  ) u_div_v (
    .clk (clk),
    .en  (en[3:1]),
    .num (pv0),
    .quo (vf3),
    .rem ()
  );

  // The secondary component is split as c = 60*a + r, so that
  // floor(c*w/60) = a*w + floor(r*w/60).
  hsv2rgb_cdiv #(
    .NW  (FB + 1),
    .PRE (0),
    .D   (HUE_SPAN),
    .QW  (QAW)
  ) u_div_a (
    .clk (clk),
    .en  (en[6:4]),
    .num (c3),
    .quo (a6),
    .rem (r6)
  );

  hsv2rgb_cdiv #(
    .NW  (RW_W),
    .PRE (0),
    .D   (HUE_SPAN),
    .QW  (WGT_W)
  ) u_div_r (
    .clk (clk),
    .en  (en[10:8]),
    .num (rw7),
    .quo (q10),
    .rem ()
  );

  always_comb begin
    hi  = rnd(side[11].vf);
    mid = rnd(xm11);
    lo  = rnd(side[11].m);
    case (side[11].sector)
      SEC_R_Y: begin red_next = hi;  green_next = mid; blue_next = lo;  end
      SEC_Y_G: begin red_next = mid; green_next = hi;  blue_next = lo;  end
      SEC_G_C: begin red_next = lo;  green_next = hi;  blue_next = mid; end
      SEC_C_B: begin red_next = lo;  green_next = mid; blue_next = hi;  end
      SEC_B_M: begin red_next = mid; green_next = lo;  blue_next = hi;  end
      default: begin red_next = hi;  green_next = lo;  blue_next = mid; end
    endcase
    if (side[11].black) begin
      red_next   = '0;
      green_next = '0;
      blue_next  = '0;
    end
  end

endmodule

// ===== hw/rtl/hsv2rgb_checker.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level assertions on the converter, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CH_W-1:0]   red,
  input logic [CH_W-1:0]   green,
  input logic [CH_W-1:0]   blue
);

  // The pipeline must come out of reset empty.
  `ASSERT_CLK(a_rst_empty, clk, $past(rst) |-> !out_valid, "result valid right after reset")

  // A stalled result keeps its value until the transaction completes.
  `ASSERT_CLK_DIS(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue), "stalled result changed")

  // With the output stage empty, every stage can move, so input is taken.
  `ASSERT_CLK_DIS(a_empty_ready, clk, rst, !out_valid |-> in_ready, "input blocked with empty output")

  // A result leaving frees room all the way back to the input.
  `ASSERT_CLK_DIS(a_drain_ready, clk, rst, out_valid && out_ready |-> in_ready, "input blocked while output drains")

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// A table of directed colors comes first. It covers the primary and secondary
// hues, both ends of every field, out-of-range hue codes and the clamping of
// saturation and value. Random colors follow. Every result transaction is
// compared field by field with an in-order queue of expected colors. Both
// sides idle at random, and the output side holds off once for a long stretch
// so that the pipeline fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
  import hsv2rgb_pkg::*;
();

  localparam int FRAC        = 20;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 200;
  localparam int N_ROWS       = 25;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;
    rgb_t             rgb;
  } color_check_t;

  // Rows with typed set carry their own expected color; the rest are predicted.
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;
    logic             typed;
    rgb_t             rgb;
  } color_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [HUE_W-1:0] hue_degrees;
  logic [PCT_W-1:0] saturation_pct;
  logic [PCT_W-1:0] value_pct;
  logic             out_valid;
  logic             out_ready;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;

  color_check_t pending_colors[$];
  color_check_t oldest_color;
  int           mismatch_count = 0;
  int           accepted_count = 0;
  int           cycle_count;
  logic         steady;

  color_row_t directed_rows [N_ROWS] = '{
    '{9'd0,   7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{9'd60,  7'd100, 7'd100, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{9'd120, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{9'd180, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{9'd240, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{9'd300, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{9'd360, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{9'd361, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd0}},
    '{9'd511, 7'd127, 7'd127, 1'b1, '{8'd0,   8'd0,   8'd0}},
    '{9'd200, 7'd0,   7'd100, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{9'd45,  7'd100, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{9'd0,   7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{9'd90,  7'd127, 7'd127, 1'b0, '0},
    '{9'd30,  7'd50,  7'd80,  1'b0, '0},
    '{9'd150, 7'd75,  7'd60,  1'b0, '0},
    '{9'd210, 7'd25,  7'd90,  1'b0, '0},
    '{9'd270, 7'd100, 7'd50,  1'b0, '0},
    '{9'd330, 7'd60,  7'd40,  1'b0, '0},
    '{9'd359, 7'd100, 7'd100, 1'b0, '0},
    '{9'd59,  7'd99,  7'd99,  1'b0, '0},
    '{9'd1,   7'd1,   7'd1,   1'b0, '0},
    '{9'd256, 7'd42,  7'd85,  1'b0, '0},
    '{9'd119, 7'd100, 7'd127, 1'b0, '0},
    '{9'd345, 7'd127, 7'd33,  1'b0, '0},
    '{9'd180, 7'd64,  7'd64,  1'b0, '0}
  };

  hsv_to_rgb_converter_top #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .hue_degrees   (hue_degrees),
    .saturation_pct(saturation_pct),
    .value_pct     (value_pct),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .red           (red),
    .green         (green),
    .blue          (blue)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Scales a fixed-point level to 8 bits, rounding half up.
  function automatic logic [63:0] level_to_channel(input logic [63:0] level);
    logic [63:0] scaled;
    scaled = (level * 255 + (64'd1 << (FRAC - 1))) >> FRAC;
    return (scaled > 255) ? 64'd255 : scaled;
  endfunction

  function automatic rgb_t convert_hsv(input logic [HUE_W-1:0] hue,
                                       input logic [PCT_W-1:0] sat,
                                       input logic [PCT_W-1:0] val);
    logic [63:0] h64;
    logic [63:0] s64;
    logic [63:0] v64;
    logic [63:0] v_fix;
    logic [63:0] c_fix;
    logic [63:0] m_fix;
    logic [63:0] x_fix;
    logic [63:0] h_mod;
    logic [63:0] hue_dist;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] lo;
    sector_t     sector;
    rgb_t        rgb;
    rgb = '0;
    if (hue > HUE_MAX) begin
      return rgb;
    end
    h64 = 64'(hue);
    s64 = 64'((sat > PCT_MAX) ? PCT_MAX : sat);
    v64 = 64'((val > PCT_MAX) ? PCT_MAX : val);
    v_fix = (v64 << FRAC) / PCT_MAX;
    c_fix = ((s64 * v64) << FRAC) / PCT_SQ;
    m_fix = v_fix - c_fix;
    h_mod = h64 % (2 * HUE_SPAN);
    hue_dist = (h_mod >= HUE_SPAN) ? (h_mod - HUE_SPAN) : (HUE_SPAN - h_mod);
    x_fix = (c_fix * (HUE_SPAN - hue_dist)) / HUE_SPAN;
    hi  = level_to_channel(c_fix + m_fix);
    mid = level_to_channel(x_fix + m_fix);
    lo  = level_to_channel(m_fix);
    // A hue of exactly 360 belongs to the last sector.
    if (h64 >= 5 * HUE_SPAN) begin
      sector = SEC_M_R;
    end else begin
      sector = sector_t'(3'(h64 / HUE_SPAN));
    end
    case (sector)
      SEC_R_Y: rgb = '{hi[7:0],  mid[7:0], lo[7:0]};
      SEC_Y_G: rgb = '{mid[7:0], hi[7:0],  lo[7:0]};
      SEC_G_C: rgb = '{lo[7:0],  hi[7:0],  mid[7:0]};
      SEC_C_B: rgb = '{lo[7:0],  mid[7:0], hi[7:0]};
      SEC_B_M: rgb = '{mid[7:0], lo[7:0],  hi[7:0]};
      default: rgb = '{hi[7:0],  lo[7:0],  mid[7:0]};
    endcase
    return rgb;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_color(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                            input logic [PCT_W-1:0] val, input rgb_t rgb_want);
    color_check_t entry;
    entry = '{hue, sat, val, rgb_want};
    while (!steady && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    hue_degrees    <= hue;
    saturation_pct <= sat;
    value_pct      <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_colors.push_back(entry);
  endtask

  // Counts accepted input transactions; the output side uses it to time its hold-off.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      accepted_count <= accepted_count + 1;
    end
  end

  initial begin
    int hold_left;
    bit hold_done;
    out_ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && accepted_count >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("color %0d/%0d/%0d with none expected", red, green, blue));
      end else begin
        oldest_color = pending_colors.pop_front();
        if (red !== oldest_color.rgb.red) begin
          report_mismatch($sformatf("hsv %0d/%0d/%0d red %0d, expected %0d",
            oldest_color.hue, oldest_color.sat, oldest_color.val, red,
            oldest_color.rgb.red));
        end
        if (green !== oldest_color.rgb.green) begin
          report_mismatch($sformatf("hsv %0d/%0d/%0d green %0d, expected %0d",
            oldest_color.hue, oldest_color.sat, oldest_color.val, green,
            oldest_color.rgb.green));
        end
        if (blue !== oldest_color.rgb.blue) begin
          report_mismatch($sformatf("hsv %0d/%0d/%0d blue %0d, expected %0d",
            oldest_color.hue, oldest_color.sat, oldest_color.val, blue,
            oldest_color.rgb.blue));
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("hsv_to_rgb_converter_top verification failed");
    $finish;
  end

  initial begin
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;
    int               kind;
    rst            = 1'b1;
    in_valid       = 1'b0;
    hue_degrees    = '0;
    saturation_pct = '0;
    value_pct      = '0;
    steady         = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_color(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].val,
                 directed_rows[i].typed ? directed_rows[i].rgb :
                 convert_hsv(directed_rows[i].hue, directed_rows[i].sat,
                             directed_rows[i].val));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // A long stretch in the middle runs with neither side idling.
      if (n == 800) steady <= 1'b1;
      if (n == 1100) steady <= 1'b0;
      kind = $urandom_range(99);
      if (kind < 70) begin
        hue = HUE_W'($urandom_range(0, HUE_MAX));
        sat = PCT_W'($urandom_range(0, PCT_MAX));
        val = PCT_W'($urandom_range(0, PCT_MAX));
      end else if (kind < 85) begin
        // Sector boundaries, saturation of 100, 0 or 1, and full or random value.
        hue = HUE_W'($urandom_range(0, 6) * HUE_SPAN);
        sat = $urandom_range(0, 1) ? PCT_MAX : PCT_W'($urandom_range(0, 1));
        val = $urandom_range(0, 1) ? PCT_MAX : PCT_W'($urandom_range(0, PCT_MAX));
      end else begin
        hue = HUE_W'($urandom_range(0, (1 << HUE_W) - 1));
        sat = PCT_W'($urandom_range(0, (1 << PCT_W) - 1));
        val = PCT_W'($urandom_range(0, (1 << PCT_W) - 1));
      end
      send_color(hue, sat, val, convert_hsv(hue, sat, val));
    end
    in_valid <= 1'b0;

    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("hsv_to_rgb_converter_top verification clean");
    end else begin
      $display("hsv_to_rgb_converter_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_cdiv.sv
hw/rtl/hsv_to_rgb_converter_top.sv
hw/rtl/hsv2rgb_checker.sv
sim/testbench.sv
